// ----- sv/hcrw_pkg.sv -----
`default_nettype none
package hcrw_pkg;

  localparam int MAX_DIGITS_DEF = 32;
  localparam int REG_COUNT_DEF  = 16;
  localparam int ACC_W          = 32;
  localparam int BYTE_W         = 8;
  localparam int WAIT_W         = 12;
  localparam int IDX_OUT_W      = 4;
  localparam int START_W        = 4;
  localparam int DIGIT_W        = 4;
  localparam int CHAR_W         = 8;
  // results per command: at most half the largest digit count, rounded up
  localparam int RES_CNT_W      = 5;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_WAIT  = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_CMD_REG   = 8'h72;
  localparam logic [CHAR_W-1:0] CHAR_CMD_VALUE = 8'h76;
  localparam logic [CHAR_W-1:0] CHAR_CMD_WAIT  = 8'h77;
  localparam logic [CHAR_W-1:0] CHAR_SKIP      = 8'h5F;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_REG,
    MODE_VALUE,
    MODE_WAIT
  } mode_t;

  typedef struct packed {
    logic                 kind;
    logic [START_W-1:0]   start_reg;
    logic [ACC_W-1:0]     acc;
    logic [RES_CNT_W-1:0] n_res;
  } cmd_t;

  typedef struct packed {
    logic               is_hex;
    logic [DIGIT_W-1:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_t r;
    r.is_hex = 1'b0;
    r.value  = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.is_hex = 1'b1;
      r.value  = DIGIT_W'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.is_hex = 1'b1;
      r.value  = DIGIT_W'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.is_hex = 1'b1;
      r.value  = DIGIT_W'(c - 8'h37);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/hcrw_in_if.sv -----
`default_nettype none
interface hcrw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface
`default_nettype wire

// ----- sv/hcrw_out_if.sv -----
`default_nettype none
interface hcrw_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [3:0]  reg_index;
  logic [7:0]  reg_value;
  logic [11:0] wait_ms;
  logic        last;

  modport source (output valid, output kind, output reg_index, output reg_value,
                  output wait_ms, output last, input ready);
  modport sink   (input valid, input kind, input reg_index, input reg_value,
                  input wait_ms, input last, output ready);
endinterface
`default_nettype wire

// ----- sv/hcrw_front.sv -----
`default_nettype none
module hcrw_front #(
  parameter int MAX_DIGITS = hcrw_pkg::MAX_DIGITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  hcrw_in_if.sink            in_chan,
  input  wire logic          q_full,
  output logic               q_push,
  output hcrw_pkg::cmd_t     q_data
);

  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  hcrw_pkg::mode_t                    mode_r, mode_nxt;
  logic [hcrw_pkg::START_W-1:0]       start_r, start_nxt;
  logic [hcrw_pkg::ACC_W-1:0]         acc_r, acc_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [CNT_W:0]                     cnt_plus;
  hcrw_pkg::hex_t                     hex;
  logic                               accept;

  assign in_chan.ready = !q_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign hex           = hcrw_pkg::hex_decode(in_chan.char_code);
  assign cnt_plus      = {1'b0, cnt_r} + (CNT_W+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= hcrw_pkg::MODE_NONE;
      start_r <= '0;
      acc_r   <= '0;
      cnt_r   <= '0;
    end else begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    start_nxt       = start_r;
    acc_nxt         = acc_r;
    cnt_nxt         = cnt_r;
    q_push          = 1'b0;
    q_data.kind     = (mode_r == hcrw_pkg::MODE_WAIT) ? hcrw_pkg::KIND_WAIT
                                                      : hcrw_pkg::KIND_WRITE;
    q_data.start_reg = start_r;
    q_data.acc      = acc_r;
    q_data.n_res    = (mode_r == hcrw_pkg::MODE_WAIT) ? hcrw_pkg::RES_CNT_W'(1)
                                                      : hcrw_pkg::RES_CNT_W'(cnt_plus >> 1);
    if (accept) begin
      if (hex.is_hex) begin
        if (mode_r == hcrw_pkg::MODE_REG) begin
          start_nxt = hex.value;
          mode_nxt  = hcrw_pkg::MODE_VALUE;
          acc_nxt   = '0;
          cnt_nxt   = '0;
        end else begin
          acc_nxt = {acc_r[hcrw_pkg::ACC_W-hcrw_pkg::DIGIT_W-1:0], hex.value};
          if (cnt_r < CNT_W'(MAX_DIGITS)) begin
            cnt_nxt = cnt_plus[CNT_W-1:0];
          end
        end
      end else if (in_chan.char_code != hcrw_pkg::CHAR_SKIP) begin
        q_push = (cnt_r != '0) &&
                 (mode_r == hcrw_pkg::MODE_VALUE || mode_r == hcrw_pkg::MODE_WAIT);
        case (in_chan.char_code)
          hcrw_pkg::CHAR_CMD_REG:   mode_nxt = hcrw_pkg::MODE_REG;
          hcrw_pkg::CHAR_CMD_VALUE: mode_nxt = hcrw_pkg::MODE_VALUE;
          hcrw_pkg::CHAR_CMD_WAIT:  mode_nxt = hcrw_pkg::MODE_WAIT;
          default:                  mode_nxt = mode_r;
        endcase
        acc_nxt = '0;
        cnt_nxt = '0;
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIGITS))
    else $error("digit count above saturation");
  a_push_mode: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (mode_r == hcrw_pkg::MODE_VALUE || mode_r == hcrw_pkg::MODE_WAIT))
    else $error("request queued outside value or wait mode");
`endif

endmodule
`default_nettype wire

// ----- sv/hcrw_queue.sv -----
`default_nettype none
module hcrw_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire hcrw_pkg::cmd_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output hcrw_pkg::cmd_t      head
);

  hcrw_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue underflow");
`endif

endmodule
`default_nettype wire

// ----- sv/hcrw_back.sv -----
`default_nettype none
module hcrw_back #(
  parameter int REG_COUNT = hcrw_pkg::REG_COUNT_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_empty,
  input  wire hcrw_pkg::cmd_t q_head,
  output logic                q_pop,
  hcrw_out_if.source          out_chan
);

  localparam int IDX_W = $clog2(REG_COUNT);

  logic [IDX_W-1:0]                first_tbl [16];
  logic                            busy_r, busy_nxt;
  logic [hcrw_pkg::RES_CNT_W-1:0]  rem_r, rem_nxt;
  logic [IDX_W-1:0]                idx_r, idx_nxt;
  logic [hcrw_pkg::ACC_W-1:0]      acc_r, acc_nxt;
  logic                            kind_r, kind_nxt;
  logic                            advance;
  logic [IDX_W+hcrw_pkg::IDX_OUT_W-1:0] idx_ext;

  logic                             out_valid_r, out_valid_nxt;
  logic                             out_kind_r;
  logic [hcrw_pkg::IDX_OUT_W-1:0]   out_index_r;
  logic [hcrw_pkg::BYTE_W-1:0]      out_value_r;
  logic [hcrw_pkg::WAIT_W-1:0]      out_wait_r;
  logic                             out_last_r;

  for (genvar k = 0; k < 16; k++) begin : g_first
    assign first_tbl[k] = IDX_W'(k % REG_COUNT);
  end

  assign q_pop   = !busy_r && !q_empty;
  assign advance = busy_r && (!out_valid_r || out_chan.ready);
  assign idx_ext = {{hcrw_pkg::IDX_OUT_W{1'b0}}, idx_r};

  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    idx_nxt  = idx_r;
    acc_nxt  = acc_r;
    kind_nxt = kind_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      rem_nxt  = q_head.n_res;
      idx_nxt  = first_tbl[q_head.start_reg];
      acc_nxt  = q_head.acc;
      kind_nxt = q_head.kind;
    end else if (advance) begin
      rem_nxt  = rem_r - hcrw_pkg::RES_CNT_W'(1);
      busy_nxt = (rem_r != hcrw_pkg::RES_CNT_W'(1));
      acc_nxt  = $signed(acc_r) >>> hcrw_pkg::BYTE_W;
      idx_nxt  = (idx_r == IDX_W'(REG_COUNT - 1)) ? '0 : idx_r + IDX_W'(1);
    end
    out_valid_nxt = advance ? 1'b1 : (out_chan.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    idx_r  <= idx_nxt;
    acc_r  <= acc_nxt;
    kind_r <= kind_nxt;
    if (advance) begin
      out_kind_r <= kind_r;
      out_last_r <= (rem_r == hcrw_pkg::RES_CNT_W'(1));
      if (kind_r == hcrw_pkg::KIND_WAIT) begin
        out_index_r <= '0;
        out_value_r <= '0;
        out_wait_r  <= acc_r[hcrw_pkg::WAIT_W-1:0];
      end else begin
        out_index_r <= idx_ext[hcrw_pkg::IDX_OUT_W-1:0];
        out_value_r <= acc_r[hcrw_pkg::BYTE_W-1:0];
        out_wait_r  <= '0;
      end
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.kind      = out_kind_r;
  assign out_chan.reg_index = out_index_r;
  assign out_chan.reg_value = out_value_r;
  assign out_chan.wait_ms   = out_wait_r;
  assign out_chan.last      = out_last_r;

`ifndef SYNTHESIS
  a_busy_rem: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r != '0)
    else $error("busy with no results left");
  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == hcrw_pkg::KIND_WAIT |-> out_last_r)
    else $error("wait request not marked last");
`endif

endmodule
`default_nettype wire

// ----- sv/hex_command_register_writer_unit.sv -----
// A terminating character's command passes the two-entry command queue between parser
// and emitter, the emitter's command registers and the output register. Throughput:
// one character per cycle; a command then emits one request per cycle while the
// receiver is ready, up to sixteen. The input stalls only while that queue is full.
// Reset: synchronous active-low rst_n clears parser state, queue and output valid.
`default_nettype none
module hex_command_register_writer_unit #(
  parameter int MAX_DIGITS = hcrw_pkg::MAX_DIGITS_DEF,
  parameter int REG_COUNT  = hcrw_pkg::REG_COUNT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hcrw_in_if.sink    in_chan,
  hcrw_out_if.source out_chan
);

  logic           q_push;
  logic           q_pop;
  logic           q_full;
  logic           q_empty;
  hcrw_pkg::cmd_t q_wdata;
  hcrw_pkg::cmd_t q_head;

  hcrw_front #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  hcrw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  hcrw_back #(
    .REG_COUNT (REG_COUNT)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule
`default_nettype wire

// ----- test/hex_command_register_writer_unit_tb.sv -----
module hex_command_register_writer_unit_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_OFF    = 8;
  localparam int PHASE_CHARS = 105;

  typedef struct packed {
    logic        kind;
    logic [3:0]  reg_index;
    logic [7:0]  reg_value;
    logic [11:0] wait_ms;
    logic        last;
  } reg_request_t;

  function automatic bit char_nibble(input logic [7:0] c, output logic [3:0] v);
    v = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = 4'(c - 8'h30);
      return 1'b1;
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      v = 4'(c - 8'h61 + 8'd10);
      return 1'b1;
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      v = 4'(c - 8'h41 + 8'd10);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  class reg_write_scoreboard;
    hcrw_pkg::mode_t mode;
    logic [3:0]      start_reg;
    logic [31:0]     acc;
    int unsigned     ndigits;
    reg_request_t    pending_q[$];
    int              errors;
    int              n_chars;
    int              n_writes;
    int              n_waits;
    int              n_full_sweeps;

    function new();
      mode          = hcrw_pkg::MODE_NONE;
      start_reg     = '0;
      acc           = '0;
      ndigits       = 0;
      errors        = 0;
      n_chars       = 0;
      n_writes      = 0;
      n_waits       = 0;
      n_full_sweeps = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      errors++;
    endtask

    function void note_char(logic [7:0] c);
      logic [3:0]   d;
      logic [31:0]  a;
      reg_request_t r;
      int           first;
      int           i;
      n_chars++;
      if (char_nibble(c, d)) begin
        if (mode == hcrw_pkg::MODE_REG) begin
          start_reg = d;
          mode      = hcrw_pkg::MODE_VALUE;
          acc       = '0;
          ndigits   = 0;
        end else begin
          acc = {acc[27:0], d};
          if (ndigits < hcrw_pkg::MAX_DIGITS_DEF) ndigits++;
        end
        return;
      end
      if (c == hcrw_pkg::CHAR_SKIP) return;
      first = pending_q.size();
      if (ndigits != 0) begin
        if (mode == hcrw_pkg::MODE_WAIT) begin
          r         = '0;
          r.kind    = hcrw_pkg::KIND_WAIT;
          r.wait_ms = acc[11:0];
          pending_q.push_back(r);
        end else if (mode == hcrw_pkg::MODE_VALUE) begin
          a = acc;
          for (i = 0; 2 * i < ndigits; i++) begin
            r           = '0;
            r.kind      = hcrw_pkg::KIND_WRITE;
            r.reg_index = start_reg + 4'(i);
            r.reg_value = a[7:0];
            pending_q.push_back(r);
            a = {{8{a[31]}}, a[31:8]};
          end
          if (ndigits >= 31) n_full_sweeps++;
        end
      end
      if (pending_q.size() > first) pending_q[pending_q.size() - 1].last = 1'b1;
      if (c == hcrw_pkg::CHAR_CMD_REG) mode = hcrw_pkg::MODE_REG;
      else if (c == hcrw_pkg::CHAR_CMD_VALUE) mode = hcrw_pkg::MODE_VALUE;
      else if (c == hcrw_pkg::CHAR_CMD_WAIT) mode = hcrw_pkg::MODE_WAIT;
      acc     = '0;
      ndigits = 0;
    endfunction

    task check_result(reg_request_t got);
      reg_request_t w;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected request %p", got));
        return;
      end
      w = pending_q.pop_front();
      if (got.kind == hcrw_pkg::KIND_WAIT) n_waits++;
      else n_writes++;
      if (got.kind !== w.kind)
        report($sformatf("kind got %0d want %0d", got.kind, w.kind));
      if (got.reg_index !== w.reg_index)
        report($sformatf("reg_index got %0d want %0d", got.reg_index, w.reg_index));
      if (got.reg_value !== w.reg_value)
        report($sformatf("reg_value got %02h want %02h", got.reg_value, w.reg_value));
      if (got.wait_ms !== w.wait_ms)
        report($sformatf("wait_ms got %0d want %0d", got.wait_ms, w.wait_ms));
      if (got.last !== w.last)
        report($sformatf("last got %0d want %0d", got.last, w.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycles = 0;
  int   send_idle_pct;
  int   recv_stall_pct;

  hcrw_in_if  in_if();
  hcrw_out_if out_if();

  reg_write_scoreboard sb = new();

  hex_command_register_writer_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d requests outstanding", cycles, sb.pending());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) sb.note_char(in_if.char_code);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result({out_if.kind, out_if.reg_index, out_if.reg_value,
                       out_if.wait_ms, out_if.last});
  end

  task automatic send_char(input logic [7:0] c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    do @(posedge clk); while (!in_if.ready);
  endtask

  function automatic logic [7:0] rand_hex();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'(8'h30 + v);
    if ($urandom_range(0, 1) == 0) return 8'(8'h61 + v - 10);
    return 8'(8'h41 + v - 10);
  endfunction

  function automatic logic [7:0] rand_terminator();
    string      cmds;
    logic [7:0] c;
    logic [3:0] d;
    cmds = "rvwrvwRVW";
    case ($urandom_range(0, 4))
      0, 1: c = cmds[$urandom_range(0, 8)];
      2: c = 8'h0D;
      3: c = 8'h20;
      default: begin
        do c = 8'($urandom_range(0, 255));
        while (char_nibble(c, d) || c == hcrw_pkg::CHAR_SKIP);
      end
    endcase
    return c;
  endfunction

  task automatic send_random_command();
    int ndig;
    int i;
    if ($urandom_range(0, 99) < 12) begin
      send_char(8'($urandom_range(0, 255)));
      return;
    end
    case ($urandom_range(0, 2))
      0: begin
        send_char(hcrw_pkg::CHAR_CMD_REG);
        if ($urandom_range(0, 9) != 0) send_char(rand_hex());
      end
      1: send_char(hcrw_pkg::CHAR_CMD_VALUE);
      default: send_char(hcrw_pkg::CHAR_CMD_WAIT);
    endcase
    ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
    for (i = 0; i < ndig; i++) begin
      if ($urandom_range(0, 9) == 0) send_char(hcrw_pkg::CHAR_SKIP);
      send_char(rand_hex());
    end
    send_char(rand_terminator());
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  initial begin
    string directed;
    int    phase;
    int    i;
    int    target;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.char_code <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // digits before any command, wrap past register 15, sign fill, wait extremes,
    // plain uppercase terminator, 'r' cut short by a non-digit
    directed = "5 rf80_1vFFFFFFFFFwfff\n0Rrz39";
    for (i = 0; i < directed.len(); i++) send_char(directed[i]);
    send_char(8'hFF);
    send_char(8'h00);
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      target = sb.n_chars + PHASE_CHARS;
      while (sb.n_chars < target) send_random_command();
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Covered %0d characters over four pacing phases: %0d register writes, %0d waits.",
             sb.n_chars, sb.n_writes, sb.n_waits);
    $display("%0d commands swept all sixteen registers; %0d mismatches.",
             sb.n_full_sweeps, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
